[rtl/core/stripe_dirty_hash_tracker_unit_macros.svh]
// Assertion macros shared by the stripe dirty hash tracker RTL.
`ifndef STRIPE_DIRTY_HASH_TRACKER_UNIT_MACROS_SVH
`define STRIPE_DIRTY_HASH_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define SDHT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stripe tracker check failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define SDHT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stripe tracker check failed");

`else

`define SDHT_ASSERT_IMP(lbl, ante, cons)
`define SDHT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/core/sdht_pkg.sv]
// Shared constants and types of the stripe dirty hash tracker.
package sdht_pkg;

	// Geometry of the display.
	localparam int ROWS              = 16;
	localparam int PIXELS_PER_STRIPE = 4096;

	// Field widths.
	localparam int OP_W   = 2;
	localparam int ROW_W  = 4;
	localparam int PIX_W  = 16;
	localparam int HASH_W = 32;

	// Only rows that the row field can name need a cache entry.
	localparam int CACHE_DEPTH = (ROWS < (1 << ROW_W)) ? ROWS : (1 << ROW_W);
	localparam int ROW_AW      = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

	// Pixel counter within one stripe.
	localparam int CNT_W = (PIXELS_PER_STRIPE > 1) ? $clog2(PIXELS_PER_STRIPE) : 1;

	// FNV-1a 32-bit offset basis (2166136261).
	localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;

	// Request operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_PIXEL   = 2'd0,
		OP_INV_ALL = 2'd1,
		OP_INV_ROW = 2'd2
	} op_e_t;

	// Status from the hash accumulator for the pixel on its input.
	typedef struct packed {
		logic              last;
		logic [HASH_W-1:0] hash;
	} acc_stat_t;

	// One finished stripe result.
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              changed;
		logic [ROW_W-1:0]  row;
	} res_t;

endpackage

[rtl/core/sdht_if.sv]
// Request and result channel interfaces of the stripe dirty hash tracker.
interface sdht_in_if;
	logic                          valid;
	logic                          ready;
	logic [sdht_pkg::OP_W-1:0]     operation;
	logic [sdht_pkg::ROW_W-1:0]    stripe_row;
	logic [sdht_pkg::PIX_W-1:0]    pixel_value;

	modport source (output valid, operation, stripe_row, pixel_value, input ready);
	modport sink (input valid, operation, stripe_row, pixel_value, output ready);
endinterface

interface sdht_out_if;
	logic                          valid;
	logic                          ready;
	logic [sdht_pkg::HASH_W-1:0]   stripe_hash;
	logic                          stripe_changed;
	logic [sdht_pkg::ROW_W-1:0]    done_row;

	modport source (output valid, stripe_hash, stripe_changed, done_row, input ready);
	modport sink (input valid, stripe_hash, stripe_changed, done_row, output ready);
endinterface

[rtl/core/sdht_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module sdht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/sdht_fnv_acc.sv]
// Running FNV-1a hash and pixel counter of the stripe being received.
module sdht_fnv_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [sdht_pkg::PIX_W-1:0]   pixel_value,
	output sdht_pkg::acc_stat_t          stat
);

	logic [sdht_pkg::HASH_W-1:0] hash_q;
	logic [sdht_pkg::CNT_W-1:0]  cnt_q;
	logic [sdht_pkg::HASH_W-1:0] mixed;
	logic [sdht_pkg::HASH_W-1:0] prod;

	// Multiply by the FNV prime 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1 as shift-add.
	function automatic logic [sdht_pkg::HASH_W-1:0] fnv_mul_prime(
		input logic [sdht_pkg::HASH_W-1:0] x
	);
		return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
	endfunction

	// Fold the incoming pixel into the running hash.
	always_comb begin
		mixed     = hash_q ^ sdht_pkg::HASH_W'(pixel_value);
		prod      = fnv_mul_prime(mixed);
		stat.hash = prod;
		stat.last = (cnt_q == sdht_pkg::CNT_W'(sdht_pkg::PIXELS_PER_STRIPE - 1));
	end

	// The hash restarts from the offset basis after the last pixel of a stripe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sdht_pkg::FNV_BASIS;
			cnt_q  <= '0;
		end else if (step) begin
			if (stat.last) begin
				hash_q <= sdht_pkg::FNV_BASIS;
				cnt_q  <= '0;
			end else begin
				hash_q <= prod;
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

endmodule

[rtl/core/stripe_dirty_hash_tracker_unit.sv]
// A stripe's last pixel passes through stage one and then the result queue before its result appears.
// Throughput: one request per cycle while the result queue has room, set by the hash feedback loop.
// The cached hash is read from a 16-entry RAM and compared in the cycle after the read.
// Reset clears the running hash, pixel count, row valid bits and result queue.
// Cache RAM contents are not cleared; an entry is used only while its valid bit is set.
`include "stripe_dirty_hash_tracker_unit_macros.svh"

module stripe_dirty_hash_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	sdht_in_if.sink     pixels,
	sdht_out_if.source  results
);

	sdht_pkg::op_e_t                 op;
	logic                            in_acc;
	logic                            end_stripe;
	sdht_pkg::acc_stat_t             stat;

	logic                            s1_valid_s1;
	logic [sdht_pkg::HASH_W-1:0]     hash_s1;
	logic [sdht_pkg::ROW_W-1:0]      row_s1;

	logic [sdht_pkg::HASH_W-1:0]     ram_rdata;
	logic                            ram_we;

	logic                            wr_vld_q;
	logic [sdht_pkg::ROW_AW-1:0]     wr_row_q;
	logic [sdht_pkg::HASH_W-1:0]     wr_hash_q;

	logic [sdht_pkg::CACHE_DEPTH-1:0] valid_q;
	logic [sdht_pkg::CACHE_DEPTH-1:0] valid_d;
	logic [sdht_pkg::CACHE_DEPTH-1:0] set_mask;
	logic [sdht_pkg::CACHE_DEPTH-1:0] clr_mask;

	logic                            in_range_s1;
	logic                            in_range_req;
	logic                            row_valid;
	logic [sdht_pkg::HASH_W-1:0]     cached;
	logic                            changed;
	sdht_pkg::res_t                  res_new;

	logic [1:0]                      cnt_q;
	sdht_pkg::res_t                  q0_q;
	sdht_pkg::res_t                  q1_q;
	logic                            pop;
	logic [2:0]                      occ;

	// Request decode and input handshake.
	assign op         = sdht_pkg::op_e_t'(pixels.operation);
	assign in_acc     = pixels.valid && pixels.ready;
	assign end_stripe = in_acc && (op == sdht_pkg::OP_PIXEL) && stat.last;

	// Accept only when the result queue can take everything in flight.
	assign pop          = results.valid && results.ready;
	assign occ          = {1'b0, cnt_q} + {2'b00, s1_valid_s1} - {2'b00, pop};
	assign pixels.ready = (occ < 3'd2);

	// Running hash over the pixels of the current stripe.
	sdht_fnv_acc u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (in_acc && (op == sdht_pkg::OP_PIXEL)),
		.pixel_value (pixels.pixel_value),
		.stat        (stat)
	);

	// Cached hash per row; read at stripe end, written back in the next cycle when it changed.
	sdht_ram #(
		.WIDTH (sdht_pkg::HASH_W),
		.DEPTH (sdht_pkg::CACHE_DEPTH)
	) u_cache (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_s1[sdht_pkg::ROW_AW-1:0]),
		.wdata (hash_s1),
		.re    (end_stripe),
		.raddr (pixels.stripe_row[sdht_pkg::ROW_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Stage one holds the finished hash while the cache read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= end_stripe;
		end
	end

	always_ff @(posedge clk) begin
		if (end_stripe) begin
			hash_s1 <= stat.hash;
			row_s1  <= pixels.stripe_row;
		end
	end

	// Compare with the cached hash; forward last cycle's write to the same row.
	always_comb begin
		in_range_s1 = (int'(row_s1) < sdht_pkg::CACHE_DEPTH);
		row_valid   = in_range_s1 && valid_q[row_s1[sdht_pkg::ROW_AW-1:0]];
		if (wr_vld_q && (wr_row_q == row_s1[sdht_pkg::ROW_AW-1:0])) begin
			cached = wr_hash_q;
		end else begin
			cached = ram_rdata;
		end
		changed         = !row_valid || (cached != hash_s1);
		ram_we          = s1_valid_s1 && in_range_s1 && changed;
		res_new.hash    = hash_s1;
		res_new.changed = changed;
		res_new.row     = row_s1;
	end

	// Last write to the cache, kept for forwarding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else begin
			wr_vld_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wr_row_q  <= row_s1[sdht_pkg::ROW_AW-1:0];
			wr_hash_q <= hash_s1;
		end
	end

	// Row valid bits: set by a cache write, then cleared by invalidations accepted now.
	always_comb begin
		in_range_req = (int'(pixels.stripe_row) < sdht_pkg::CACHE_DEPTH);
		set_mask     = '0;
		clr_mask     = '0;
		if (ram_we) begin
			set_mask[row_s1[sdht_pkg::ROW_AW-1:0]] = 1'b1;
		end
		if (in_acc && (op == sdht_pkg::OP_INV_ROW) && in_range_req) begin
			clr_mask[pixels.stripe_row[sdht_pkg::ROW_AW-1:0]] = 1'b1;
		end
		if (in_acc && (op == sdht_pkg::OP_INV_ALL)) begin
			valid_d = '0;
		end else begin
			valid_d = (valid_q | set_mask) & ~clr_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Two-entry result queue: output register plus skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (s1_valid_s1 && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (!s1_valid_s1 && pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && pop) begin
			if (cnt_q == 2'd1) begin
				q0_q <= res_new;
			end else begin
				q0_q <= q1_q;
				q1_q <= res_new;
			end
		end else if (pop) begin
			q0_q <= q1_q;
		end else if (s1_valid_s1) begin
			if (cnt_q == 2'd0) begin
				q0_q <= res_new;
			end else begin
				q1_q <= res_new;
			end
		end
	end

	// Result channel driven from the head of the queue.
	assign results.valid          = (cnt_q != 2'd0);
	assign results.stripe_hash    = q0_q.hash;
	assign results.stripe_changed = q0_q.changed;
	assign results.done_row       = q0_q.row;

	// A finished stripe always finds room in the result queue.
	`SDHT_ASSERT_IMP(a_queue_room, s1_valid_s1, (cnt_q != 2'd2) || pop)

	// An invalidate-all with no cache write pending leaves every row invalid.
	`SDHT_ASSERT_NXT(a_inv_all_clears, in_acc && (op == sdht_pkg::OP_INV_ALL) && !ram_we, valid_q == '0)

	// The queue never holds more than two results.
	`SDHT_ASSERT_IMP(a_queue_bound, 1'b1, cnt_q != 2'd3)

endmodule

[tb/tb_stripe_dirty_hash_tracker_unit.sv]
// Self-checking testbench of the stripe dirty hash tracker, with its own stripe hash predictor.
module tb_stripe_dirty_hash_tracker_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [sdht_pkg::HASH_W-1:0] FNV_PRIME = 32'd16777619;
	// Operation code that the block must ignore.
	localparam logic [sdht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	// A stripe position past the end means no side request is inserted.
	localparam int unsigned NO_SIDE      = sdht_pkg::PIXELS_PER_STRIPE;
	localparam int unsigned RANDOM_STRIPES = 44;
	localparam int unsigned TAIL_REQUESTS  = 20000;
	localparam int unsigned HOLD_CYCLES    = 60000;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned CYCLE_LIMIT    = 12000000;

	typedef struct packed {
		logic [sdht_pkg::OP_W-1:0]  operation;
		logic [sdht_pkg::ROW_W-1:0] row;
		logic [sdht_pkg::PIX_W-1:0] pixel;
	} pix_req_t;

	logic clk;
	logic arst_n;

	sdht_in_if  pixels_if ();
	sdht_out_if results_if ();

	stripe_dirty_hash_tracker_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pixels_if),
		.results (results_if)
	);

	// Requests waiting to be offered, and stripe results still owed by the block.
	pix_req_t       pending_requests[$];
	sdht_pkg::res_t expected_stripes[$];

	// Predicted state of the tracker.
	logic [sdht_pkg::HASH_W-1:0] pred_hash;
	int unsigned                 pred_count;
	logic [sdht_pkg::HASH_W-1:0] pred_cache [sdht_pkg::ROWS];
	logic [sdht_pkg::ROWS-1:0]   pred_valid;

	// Content currently held by each row, so that stripes can be repeated.
	int unsigned                row_seed [sdht_pkg::ROWS];
	int unsigned                row_flip_at [sdht_pkg::ROWS];
	logic [sdht_pkg::PIX_W-1:0] row_flip_mask [sdht_pkg::ROWS];

	pix_req_t    staged_req;
	int unsigned in_gap;
	int unsigned out_gap;
	bit          hold_results;
	int unsigned results_seen;
	int unsigned failures;
	int unsigned cycle_count;

	// Clock with a period of 8 ns.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pixel content of a stripe; seed zero alternates all-zero and all-one pixels.
	function automatic logic [sdht_pkg::PIX_W-1:0] stripe_pixel(int unsigned seed,
			int unsigned idx);
		logic [31:0] x;
		if (seed == 0)
			return idx[0] ? '1 : '0;
		x = seed ^ (idx * 32'h9E37_79B9);
		x ^= x >> 16;
		x *= 32'h85EB_CA6B;
		x ^= x >> 13;
		x *= 32'hC2B2_AE35;
		x ^= x >> 16;
		return x[sdht_pkg::PIX_W-1:0];
	endfunction

	// A stray request: mostly ignored codes and single-row invalidations.
	function automatic pix_req_t stray_request();
		pix_req_t req;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		req.row = sdht_pkg::ROW_W'($urandom_range(0, sdht_pkg::ROWS - 1));
		req.pixel = sdht_pkg::PIX_W'($urandom_range(0, 16'hFFFF));
		if (pick < 5)
			req.operation = OP_UNUSED;
		else if (pick < 9)
			req.operation = sdht_pkg::OP_INV_ROW;
		else
			req.operation = sdht_pkg::OP_INV_ALL;
		return req;
	endfunction

	function automatic bit in_tail();
		return pending_requests.size() < TAIL_REQUESTS;
	endfunction

	// Queue one whole stripe; only the last pixel carries the stripe's row.
	task automatic queue_stripe(input int unsigned seed, input int unsigned flip_at,
			input logic [sdht_pkg::PIX_W-1:0] flip_mask, input logic [sdht_pkg::ROW_W-1:0] row,
			input bit noisy, input int unsigned side_at, input pix_req_t side_req);
		pix_req_t req;
		for (int unsigned i = 0; i < sdht_pkg::PIXELS_PER_STRIPE; i++) begin
			if (i == side_at)
				pending_requests.push_back(side_req);
			if (noisy && $urandom_range(0, 2047) == 0)
				pending_requests.push_back(stray_request());
			req.operation = sdht_pkg::OP_PIXEL;
			req.row = (i == sdht_pkg::PIXELS_PER_STRIPE - 1) ? row :
				sdht_pkg::ROW_W'($urandom_range(0, sdht_pkg::ROWS - 1));
			req.pixel = stripe_pixel(seed, i);
			if (i == flip_at)
				req.pixel ^= flip_mask;
			pending_requests.push_back(req);
		end
	endtask

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%s", msg);
	endtask

	// Fold one accepted request into the predicted state.
	task automatic track_stripe_request(input pix_req_t req);
		sdht_pkg::res_t done;
		case (sdht_pkg::op_e_t'(req.operation))
			sdht_pkg::OP_INV_ALL: begin
				pred_valid = '0;
			end
			sdht_pkg::OP_INV_ROW: begin
				if (req.row < sdht_pkg::ROWS)
					pred_valid[req.row] = 1'b0;
			end
			sdht_pkg::OP_PIXEL: begin
				pred_hash = (pred_hash ^
					{{(sdht_pkg::HASH_W - sdht_pkg::PIX_W){1'b0}}, req.pixel}) * FNV_PRIME;
				pred_count++;
				if (pred_count == sdht_pkg::PIXELS_PER_STRIPE) begin
					done.hash = pred_hash;
					done.changed = 1'b1;
					done.row = req.row;
					if (req.row < sdht_pkg::ROWS) begin
						done.changed = !pred_valid[req.row] ||
							pred_cache[req.row] != pred_hash;
						if (done.changed) begin
							pred_cache[req.row] = pred_hash;
							pred_valid[req.row] = 1'b1;
						end
					end
					expected_stripes.push_back(done);
					pred_hash = sdht_pkg::FNV_BASIS;
					pred_count = 0;
				end
			end
			default: begin
			end
		endcase
	endtask

	// Request driver: holds each request until accepted, with random idle bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixels_if.valid && pixels_if.ready)
				track_stripe_request({pixels_if.operation, pixels_if.stripe_row,
					pixels_if.pixel_value});
			if (!pixels_if.valid || pixels_if.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					pixels_if.valid <= 1'b0;
				end else if (!in_tail() && $urandom_range(0, 9) == 0) begin
					in_gap = $urandom_range(0, 12);
					pixels_if.valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					staged_req = pending_requests.pop_front();
					pixels_if.operation <= staged_req.operation;
					pixels_if.stripe_row <= staged_req.row;
					pixels_if.pixel_value <= staged_req.pixel;
					pixels_if.valid <= 1'b1;
				end else begin
					pixels_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each stripe result and stalls the result side at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				results_seen++;
				if (expected_stripes.size() == 0) begin
					note_failure($sformatf("unexpected result: hash %h changed %0b row %0d",
						results_if.stripe_hash, results_if.stripe_changed,
						results_if.done_row));
				end else begin
					if (results_if.stripe_hash !== expected_stripes[0].hash ||
							results_if.stripe_changed !== expected_stripes[0].changed ||
							results_if.done_row !== expected_stripes[0].row)
						note_failure($sformatf({"mismatch: expected hash %h changed %0b ",
							"row %0d, got hash %h changed %0b row %0d"},
							expected_stripes[0].hash, expected_stripes[0].changed,
							expected_stripes[0].row, results_if.stripe_hash,
							results_if.stripe_changed, results_if.done_row));
					void'(expected_stripes.pop_front());
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				results_if.ready <= 1'b0;
			end else if (!in_tail() && $urandom_range(0, 9) == 0) begin
				out_gap = $urandom_range(0, 12);
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= !hold_results;
			end
		end
	end

	// One long stall on the result side so that the block backs up into its input.
	initial begin
		hold_results = 1'b0;
		while (results_seen < 6)
			@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		pix_req_t side;
		logic [sdht_pkg::ROW_W-1:0] row;
		int unsigned pick;

		clk = 1'b0;
		arst_n = 1'b0;
		pixels_if.valid = 1'b0;
		pixels_if.operation = '0;
		pixels_if.stripe_row = '0;
		pixels_if.pixel_value = '0;
		results_if.ready = 1'b0;
		in_gap = 0;
		out_gap = 0;
		results_seen = 0;
		failures = 0;
		cycle_count = 0;
		pred_hash = sdht_pkg::FNV_BASIS;
		pred_count = 0;
		pred_valid = '0;
		for (int i = 0; i < sdht_pkg::ROWS; i++) begin
			pred_cache[i] = '0;
			row_seed[i] = $urandom | 1;
			row_flip_at[i] = NO_SIDE;
			row_flip_mask[i] = '0;
		end

		// Opening requests: ignored code and invalidations while nothing is cached.
		pending_requests.push_back({OP_UNUSED, 4'hF, 16'hFFFF});
		pending_requests.push_back({sdht_pkg::OP_INV_ALL, 4'h0, 16'h0000});
		pending_requests.push_back({sdht_pkg::OP_INV_ROW, 4'h0, 16'hFFFF});
		pending_requests.push_back({sdht_pkg::OP_INV_ROW, 4'hF, 16'h0000});

		// Extreme pixels on row 0: first pass is new, the repeat is unchanged even
		// with another row invalidated mid-stripe.
		side = '0;
		queue_stripe(0, NO_SIDE, '0, 4'h0, 1'b0, NO_SIDE, side);
		side = {sdht_pkg::OP_INV_ROW, 4'h7, 16'h0000};
		queue_stripe(0, NO_SIDE, '0, 4'h0, 1'b0, 2000, side);
		// Invalidated row reports a change although the hash matches.
		pending_requests.push_back({sdht_pkg::OP_INV_ROW, 4'h0, 16'h1234});
		queue_stripe(0, NO_SIDE, '0, 4'h0, 1'b0, NO_SIDE, side);
		// A differing last pixel changes the hash of a valid row.
		side = {sdht_pkg::OP_INV_ROW, 4'h3, 16'h0000};
		queue_stripe(0, sdht_pkg::PIXELS_PER_STRIPE - 1, 16'h8001, 4'h0, 1'b0, 100, side);
		// Invalidate-all in the middle of a stripe leaves the running hash alone.
		side = {sdht_pkg::OP_INV_ALL, 4'h5, 16'hAAAA};
		queue_stripe(0, NO_SIDE, '0, 4'hF, 1'b0, 1000, side);
		side = '0;
		queue_stripe(0, NO_SIDE, '0, 4'hF, 1'b0, NO_SIDE, side);
		side = {sdht_pkg::OP_INV_ROW, 4'hF, 16'h5555};
		queue_stripe(0, NO_SIDE, '0, 4'hF, 1'b0, 3000, side);

		// Random stripes: repeats of a row's content, small edits and fresh content.
		for (int unsigned s = 0; s < RANDOM_STRIPES; s++) begin
			row = sdht_pkg::ROW_W'($urandom_range(0, sdht_pkg::ROWS - 1));
			pick = $urandom_range(0, 9);
			if (pick >= 7) begin
				row_seed[row] = $urandom | 1;
				row_flip_at[row] = NO_SIDE;
				row_flip_mask[row] = '0;
			end else if (pick >= 5) begin
				row_flip_at[row] = $urandom_range(0, sdht_pkg::PIXELS_PER_STRIPE - 1);
				row_flip_mask[row] = sdht_pkg::PIX_W'($urandom_range(1, 16'hFFFF));
			end
			if ($urandom_range(0, 2) == 0)
				pending_requests.push_back(stray_request());
			side = '0;
			queue_stripe(row_seed[row], row_flip_at[row], row_flip_mask[row], row, 1'b1,
				NO_SIDE, side);
		end

		// Reset held and then released on a falling edge, away from the rising edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() > 0 || pixels_if.valid)
			@(posedge clk);
		while (expected_stripes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && expected_stripes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
